// ----- sv/svm_pkg.sv -----
// Shared types and constants for the sample voice mixer.
// Used by svm_ctrl, svm_dp and sample_voice_mixer; depends on nothing.
package svm_pkg;

    localparam int ACT_W  = 2;
    localparam int LEN_W  = 13;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 4;
    localparam int CIDX_W = 1;

    // Item actions.
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_OUT_EN = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_VOICES = 1'd1;

    localparam logic [CFG_W-1:0]  VOICES_RST = 4'd8;
    localparam logic [BYTE_W-1:0] BYTE_BIAS  = 8'd127;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // start item transfer: cancel load, latch length and loop
        logic data;     // data item transfer
        logic clear;    // clear item transfer
        logic claim;    // claim the voice at the scan index
        logic mix;      // read and advance the voice at the scan index
        logic acc_clr;  // clear the mix accumulator
        logic emit;     // load the accumulator into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_en;   // output enabled
        logic no_voice;  // no voice slot usable
        logic len_zero;  // start item announces an empty sample
        logic idx_free;  // voice at the scan index is not active
        logic out_busy;  // output register holds a result that is not taken
    } t_stat;

endpackage

// ----- sv/sample_voice_mixer.sv -----
// Top level of the sample voice mixer: controller plus datapath.
// Depends on svm_pkg, svm_ctrl and svm_dp.
//
//  Channel  Direction  Handshake                  Payload
//  input    in         i_in_valid / o_in_ready    action, sample_length, loop_flag, sample_byte
//  output   out        o_out_valid / i_out_ready  mixed_sample
//  config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A data, clear or zero-length start item, a start item with no usable slot, or a
// tick with output disabled, is done in its accepting cycle. Other start items scan
// voice slots from the top down, one slot a cycle, until a free slot is claimed or
// slot 0 is checked. An enabled tick runs the accepting cycle, one sample memory
// read per usable voice, a step to add the last byte and the output register load,
// which waits while a result is still untaken; with no usable slot only the load
// follows. Reset is synchronous; the sample memory needs no clearing pass.
module sample_voice_mixer
    import svm_pkg::*;
#(
    parameter int VOICES      = 8,
    parameter int VOICE_BYTES = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [LEN_W-1:0]         i_sample_length,
    input  logic                     i_loop_flag,
    input  logic [BYTE_W-1:0]        i_sample_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [BYTE_W-1:0] o_mixed_sample,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [VW-1:0] w_idx;
    logic [VW-1:0] w_last_idx;

    svm_ctrl #(
        .VW(VW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .i_last_idx (w_last_idx),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    svm_dp #(
        .VOICES      (VOICES),
        .VOICE_BYTES (VOICE_BYTES),
        .VW          (VW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_length (i_sample_length),
        .i_loop_flag     (i_loop_flag),
        .i_sample_byte   (i_sample_byte),
        .i_cmd           (w_cmd),
        .i_idx           (w_idx),
        .o_stat          (w_stat),
        .o_last_idx      (w_last_idx),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mixed_sample  (o_mixed_sample)
    );

    // The output register is only loaded when its previous result has gone.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !w_stat.out_busy)
        else $error("result loaded over an untaken result");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    // No slot walk runs while an item transfer can be taken.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mix || w_cmd.claim) |-> !o_in_ready)
        else $error("slot walk while accepting items");

    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mix |-> (w_idx <= w_last_idx) && !w_stat.no_voice)
        else $error("mix beyond the usable voices");

endmodule

// ----- sv/svm_ctrl.sv -----
// Controller state machine for the sample voice mixer.
// Decodes accepted items and walks the voice slots; depends on svm_pkg.
module svm_ctrl
    import svm_pkg::*;
#(
    parameter int VW = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ACT_W-1:0] i_action,
    input  t_stat            i_stat,
    input  logic [VW-1:0]    i_last_idx,
    output t_cmd             o_cmd,
    output logic [VW-1:0]    o_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_DRAIN,
        S_EMIT,
        S_CLAIM
    } t_state;

    t_state        r_state, n_state;
    logic [VW-1:0] r_idx, n_idx;
    logic          w_take;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;
    assign o_idx      = r_idx;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_action)
                        ACT_TICK: begin
                            if (i_stat.tick_en) begin
                                o_cmd.acc_clr = 1'b1;
                                n_idx         = '0;
                                n_state       = i_stat.no_voice ? S_EMIT : S_MIX;
                            end
                        end
                        ACT_START: begin
                            o_cmd.start = 1'b1;
                            if (!i_stat.len_zero && !i_stat.no_voice) begin
                                n_idx   = i_last_idx;
                                n_state = S_CLAIM;
                            end
                        end
                        ACT_DATA:  o_cmd.data  = 1'b1;
                        ACT_CLEAR: o_cmd.clear = 1'b1;
                        default:   ;
                    endcase
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                if (r_idx == i_last_idx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // The read of the last voice lands in the accumulator here.
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CLAIM: begin
                if (i_stat.idx_free) begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- sv/svm_dp.sv -----
// Datapath for the sample voice mixer: configuration, voice state, sample
// memory, accumulator and output register. Depends on svm_pkg.
module svm_dp
    import svm_pkg::*;
#(
    parameter int VOICES      = 8,
    parameter int VOICE_BYTES = 4096,
    parameter int VW          = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [LEN_W-1:0]         i_sample_length,
    input  logic                     i_loop_flag,
    input  logic [BYTE_W-1:0]        i_sample_byte,
    input  t_cmd                     i_cmd,
    input  logic [VW-1:0]            i_idx,
    output t_stat                    o_stat,
    output logic [VW-1:0]            o_last_idx,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [BYTE_W-1:0] o_mixed_sample
);

    localparam int PW    = $clog2(VOICE_BYTES);
    localparam int NW    = $clog2(VOICES + 1);
    localparam int DEPTH = VOICES * (2 ** PW);
    localparam int AW    = $clog2(DEPTH);

    // Configuration.
    logic             r_out_en;
    logic [CFG_W-1:0] r_voices;

    // Per-voice state.
    logic             r_active [VOICES];
    logic             r_repeat [VOICES];
    logic [LEN_W-1:0] r_vlen   [VOICES];
    logic [LEN_W-1:0] r_pos    [VOICES];

    // Load state and latched start item.
    logic             r_load_busy;
    logic [VW-1:0]    r_load_voice;
    logic [LEN_W-1:0] r_load_cnt;
    logic [LEN_W-1:0] r_load_len;
    logic [LEN_W-1:0] r_len;
    logic             r_loop;

    // Sample memory and mixing.
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_take;
    logic [BYTE_W-1:0] r_acc;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out;

    logic [NW-1:0]    w_n;
    logic [LEN_W-1:0] w_len_sat;
    logic [LEN_W-1:0] w_pos_inc;
    logic [LEN_W-1:0] w_cnt_inc;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr;

    assign w_n        = (32'(r_voices) > VOICES) ? NW'(VOICES) : NW'(r_voices);
    assign o_last_idx = VW'(w_n - NW'(1));
    assign w_len_sat  = (32'(i_sample_length) > VOICE_BYTES) ? LEN_W'(VOICE_BYTES)
                                                             : i_sample_length;
    assign w_pos_inc  = r_pos[i_idx] + 1'b1;
    assign w_cnt_inc  = r_load_cnt + 1'b1;
    assign w_wr       = i_cmd.data && r_load_busy;
    assign w_wr_addr  = AW'({r_load_voice, PW'(r_load_cnt)});
    assign w_rd_addr  = AW'({i_idx, PW'(r_pos[i_idx])});

    assign o_stat.tick_en  = r_out_en;
    assign o_stat.no_voice = (w_n == '0);
    assign o_stat.len_zero = (i_sample_length == '0);
    assign o_stat.idx_free = !r_active[i_idx];
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_mixed_sample = signed'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_en <= 1'b0;
            r_voices <= VOICES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OUT_EN: r_out_en <= i_cfg_data[0];
                CFG_VOICES: r_voices <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_active[v] <= 1'b0;
                r_repeat[v] <= 1'b0;
                r_vlen[v]   <= '0;
                r_pos[v]    <= '0;
            end
            r_load_busy  <= 1'b0;
            r_load_voice <= '0;
            r_load_cnt   <= '0;
            r_load_len   <= '0;
        end else begin
            if (i_cmd.clear) begin
                for (int v = 0; v < VOICES; v++) begin
                    r_active[v] <= 1'b0;
                    r_pos[v]    <= '0;
                end
                r_load_busy <= 1'b0;
                r_load_cnt  <= '0;
            end
            if (i_cmd.start) begin
                r_load_busy <= 1'b0;
                r_load_cnt  <= '0;
            end
            if (w_wr) begin
                // The voice goes live once its last byte is stored.
                if (w_cnt_inc >= r_load_len) begin
                    r_active[r_load_voice] <= 1'b1;
                    r_pos[r_load_voice]    <= '0;
                    r_load_busy            <= 1'b0;
                    r_load_cnt             <= '0;
                end else begin
                    r_load_cnt <= w_cnt_inc;
                end
            end
            if (i_cmd.claim) begin
                r_load_busy     <= 1'b1;
                r_load_voice    <= i_idx;
                r_load_len      <= r_len;
                r_vlen[i_idx]   <= r_len;
                r_repeat[i_idx] <= r_loop;
                r_pos[i_idx]    <= '0;
            end
            if (i_cmd.mix && r_active[i_idx]) begin
                if (w_pos_inc >= r_vlen[i_idx]) begin
                    r_pos[i_idx] <= '0;
                    if (!r_repeat[i_idx]) begin
                        r_active[i_idx] <= 1'b0;
                    end
                end else begin
                    r_pos[i_idx] <= w_pos_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_len  <= w_len_sat;
            r_loop <= i_loop_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_wr_addr] <= i_sample_byte - BYTE_BIAS;
        end
        if (i_cmd.mix) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_take   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_take <= i_cmd.mix && r_active[i_idx];
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
            end else if (r_rd_take) begin
                r_acc <= r_acc + r_rd_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_acc;
        end
    end

endmodule
